### rtl/core/hmd5_pkg.sv
// ----------------------------------------------------------------------------
// hmd5_pkg
// Shared types, constants and round tables for the HMAC-MD5 stream block.
// ----------------------------------------------------------------------------
package hmd5_pkg;

    localparam logic [31:0] IPAD_WORD = 32'h36363636;
    localparam logic [31:0] OPAD_WORD = 32'h5c5c5c5c;
    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [7:0]  ADDR_KEY_LOW  = 8'h00;
    localparam logic [7:0]  ADDR_KEY_HIGH = 8'h08;
    localparam logic [7:0]  ADDR_KEY_LEN  = 8'h10;

    localparam logic [127:0] MD5_IV =
        {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

    typedef struct packed {
        logic        last;
        logic [2:0]  valid_bytes;
        logic [31:0] msg_word;
    } in_word_t;

    typedef struct packed {
        logic [63:0] mac_high;
        logic [63:0] mac_low;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_IKEY, ST_BYTE, ST_PAD_ONE, ST_PAD_ZERO, ST_PAD_LEN,
        ST_OKEY, ST_OBLK, ST_COMP, ST_OUT
    } state_t;

    // Where a compression run returns when done
    typedef enum logic [1:0] {
        RET_BYTE, RET_PAD, RET_OBLK, RET_OUT
    } ret_t;

    // Datapath byte source select
    typedef enum logic [1:0] {
        SRC_MSG, SRC_PAD, SRC_ZERO, SRC_LEN
    } bsrc_t;

    typedef struct packed {
        logic  load_word;   // capture the accepted word, restart byte index
        logic  open_msg;    // latch key, set counter to 64, load ikey block, iv
        logic  put_byte;    // write one byte into the buffer
        bsrc_t bsrc;
        logic  comp_start;  // begin 64 rounds
        logic  load_okey;   // load okey block, save inner digest
        logic  load_oblk;   // load digest block for outer compress
        logic  finish;      // capture mac
    } cmd_t;

    typedef struct packed {
        logic       comp_busy;
        logic       blk_full;   // this put_byte fills a block
        logic [5:0] pos;        // byte position in block
        logic [2:0] byte_idx;   // bytes of the current word written so far
        logic [2:0] len_idx;
    } sts_t;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        return k[i];
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] i);
        logic [4:0] s [16];
        s = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
              5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
        return s[{i[5:4], i[1:0]}];
    endfunction

endpackage

### rtl/core/hmd5_ctrl.sv
// ----------------------------------------------------------------------------
// hmd5_ctrl
// Sequencer: walks bytes of each word, padding, length, both key blocks and the outer block.
// ----------------------------------------------------------------------------
module hmd5_ctrl import hmd5_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  in_word_t in_word,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  sts_t     sts,
    output cmd_t     cmd
);

    state_t     state_reg, state_next;
    ret_t       ret_reg, ret_next;
    logic       open_reg, open_next;
    logic       out_valid_reg, out_valid_next;
    logic [2:0] nbytes_reg, nbytes_next;
    logic       last_reg, last_next;
    logic [2:0] nb_in;

    assign nb_in = (in_word.valid_bytes > 3'd4) ? 3'd4 : in_word.valid_bytes;
    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= RET_BYTE;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            nbytes_reg    <= '0;
            last_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
            nbytes_reg    <= nbytes_next;
            last_reg      <= last_next;
        end
    end

    // Next state
    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        open_next      = open_reg;
        nbytes_next    = nbytes_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_ready) begin
                    nbytes_next = nb_in;
                    last_next   = in_word.last;
                    open_next   = 1'b1;
                    if (!open_reg) begin
                        state_next = ST_COMP;
                        ret_next   = RET_BYTE;
                    end else begin
                        state_next = ST_BYTE;
                    end
                end
            end
            ST_BYTE: begin
                if (sts.byte_idx == nbytes_reg) begin
                    state_next = last_reg ? ST_PAD_ONE : ST_IDLE;
                end else if (sts.blk_full) begin
                    state_next = ST_COMP;
                    ret_next   = RET_BYTE;
                end
            end
            ST_PAD_ONE, ST_PAD_ZERO: begin
                if (sts.blk_full) begin
                    state_next = ST_COMP;
                    ret_next   = RET_PAD;
                end else begin
                    state_next = (sts.pos == 6'd55) ? ST_PAD_LEN : ST_PAD_ZERO;
                end
            end
            ST_PAD_LEN: begin
                if (sts.blk_full) begin
                    state_next = ST_COMP;
                    ret_next   = RET_OBLK;
                end
            end
            ST_OKEY: begin
                state_next = ST_COMP;
                ret_next   = RET_OBLK;
            end
            ST_OBLK: begin
                state_next = ST_COMP;
                ret_next   = RET_OUT;
            end
            ST_COMP: begin
                if (!sts.comp_busy) begin
                    case (ret_reg)
                        RET_BYTE: state_next = ST_BYTE;
                        RET_PAD:  state_next = (sts.pos == 6'd56) ? ST_PAD_LEN
                                                                  : ST_PAD_ZERO;
                        RET_OBLK: state_next = last_reg ? ST_OKEY : ST_OBLK;
                        RET_OUT:  state_next = ST_OUT;
                        default:  state_next = ST_IDLE;
                    endcase
                    if (ret_reg == RET_OBLK) last_next = 1'b0;
                end
            end
            ST_OUT: begin
                out_valid_next = 1'b1;
                open_next      = 1'b0;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd = '0;
        cmd.bsrc = SRC_MSG;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_ready) begin
                    cmd.load_word = 1'b1;
                    if (!open_reg) begin
                        cmd.open_msg   = 1'b1;
                        cmd.comp_start = 1'b1;
                    end
                end
            end
            ST_BYTE: begin
                if (sts.byte_idx != nbytes_reg) cmd.put_byte = 1'b1;
            end
            ST_PAD_ONE: begin
                cmd.put_byte = 1'b1;
                cmd.bsrc     = SRC_PAD;
            end
            ST_PAD_ZERO: begin
                cmd.put_byte = 1'b1;
                cmd.bsrc     = SRC_ZERO;
            end
            ST_PAD_LEN: begin
                cmd.put_byte = 1'b1;
                cmd.bsrc     = SRC_LEN;
            end
            ST_OKEY: begin
                cmd.load_okey  = 1'b1;
                cmd.comp_start = 1'b1;
            end
            ST_OBLK: begin
                cmd.load_oblk  = 1'b1;
                cmd.comp_start = 1'b1;
            end
            ST_COMP: begin
                if (!sts.comp_busy && (ret_reg == RET_BYTE || ret_reg == RET_PAD))
                    cmd.comp_start = 1'b0;
            end
            ST_OUT:  cmd.finish = 1'b1;
            default: cmd = '0;
        endcase
    end

endmodule

### rtl/core/hmd5_dp.sv
// ----------------------------------------------------------------------------
// hmd5_dp
// Datapath: block buffer, byte counter, chain value and one MD5 round a cycle.
// ----------------------------------------------------------------------------
module hmd5_dp import hmd5_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  cmd_t         cmd,
    input  logic [31:0]  msg_word,
    input  logic [127:0] key_in,
    output sts_t         sts,
    output logic [127:0] mac
);

    logic [31:0]  blk_reg [16];
    logic [127:0] key_reg;
    logic [127:0] chain_reg;
    logic [127:0] inner_reg;
    logic [127:0] mac_reg;
    logic [63:0]  cnt_reg;
    logic [63:0]  bits_reg;
    logic [31:0]  word_reg;
    logic [2:0]   bidx_reg;
    logic [2:0]   lidx_reg;
    logic         full_reg;
    logic         busy_reg;
    logic [5:0]   rnd_reg;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg;

    logic [5:0]   pos;
    logic [7:0]   byte_val;
    logic [31:0]  f;
    logic [3:0]   g;
    logic [31:0]  sum, rot;
    logic [63:0]  rot2;

    assign pos = cnt_reg[5:0];

    // Byte source
    always_comb begin
        case (cmd.bsrc)
            SRC_MSG:  byte_val = word_reg[{bidx_reg[1:0], 3'b000} +: 8];
            SRC_PAD:  byte_val = PAD_BYTE;
            SRC_ZERO: byte_val = 8'h00;
            SRC_LEN:  byte_val = bits_reg[{lidx_reg, 3'b000} +: 8];
            default:  byte_val = 8'h00;
        endcase
    end

    // Round function
    always_comb begin
        case (rnd_reg[5:4])
            2'd0: begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                g = rnd_reg[3:0];
            end
            2'd1: begin
                f = (d_reg & b_reg) | (~d_reg & c_reg);
                g = 4'(5 * rnd_reg[3:0] + 1);
            end
            2'd2: begin
                f = b_reg ^ c_reg ^ d_reg;
                g = 4'(3 * rnd_reg[3:0] + 5);
            end
            default: begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = 4'(7 * rnd_reg[3:0]);
            end
        endcase
        sum  = a_reg + f + md5_k(rnd_reg) + blk_reg[g];
        rot2 = {sum, sum} << md5_s(rnd_reg);
        rot  = rot2[63:32];
    end

    // Buffer, counters and round engine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            full_reg  <= 1'b0;
            cnt_reg   <= '0;
            bidx_reg  <= '0;
            lidx_reg  <= '0;
            rnd_reg   <= '0;
            chain_reg <= MD5_IV;
        end else begin
            full_reg <= 1'b0;
            if (cmd.open_msg) begin
                key_reg <= key_in;
                cnt_reg <= 64'd64;
                for (int i = 0; i < 16; i++)
                    blk_reg[i] <= ((i < 4) ? key_in[32*i +: 32] : 32'h0) ^ IPAD_WORD;
                chain_reg <= MD5_IV;
            end
            // Hold the accepted word while its bytes are written
            if (cmd.load_word) begin
                word_reg <= msg_word;
                bidx_reg <= '0;
            end
            if (cmd.put_byte) begin
                blk_reg[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= byte_val;
                cnt_reg  <= cnt_reg + 64'd1;
                full_reg <= (pos == 6'd63);
                if (cmd.bsrc == SRC_MSG) bidx_reg <= bidx_reg + 3'd1;
                if (cmd.bsrc == SRC_PAD) begin
                    bits_reg <= {cnt_reg[60:0], 3'b000};
                    lidx_reg <= '0;
                end
                if (cmd.bsrc == SRC_LEN) lidx_reg <= lidx_reg + 3'd1;
            end
            if (cmd.load_okey) begin
                inner_reg <= chain_reg;
                chain_reg <= MD5_IV;
                for (int i = 0; i < 16; i++)
                    blk_reg[i] <= ((i < 4) ? key_reg[32*i +: 32] : 32'h0) ^ OPAD_WORD;
            end
            if (cmd.load_oblk) begin
                for (int i = 0; i < 16; i++)
                    blk_reg[i] <= (i < 4) ? inner_reg[32*i +: 32] :
                                  (i == 4) ? 32'h80 : (i == 14) ? 32'd640 : 32'h0;
            end
            if (cmd.comp_start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
                if (cmd.open_msg || cmd.load_okey) begin
                    {d_reg, c_reg, b_reg, a_reg} <= MD5_IV;
                end else begin
                    {d_reg, c_reg, b_reg, a_reg} <= chain_reg;
                end
            end else if (full_reg) begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
                {d_reg, c_reg, b_reg, a_reg} <= chain_reg;
            end else if (busy_reg) begin
                a_reg <= d_reg;
                d_reg <= c_reg;
                c_reg <= b_reg;
                b_reg <= b_reg + rot;
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    busy_reg  <= 1'b0;
                    chain_reg <= {chain_reg[127:96] + c_reg,
                                  chain_reg[95:64] + b_reg,
                                  chain_reg[63:32] + b_reg + rot,
                                  chain_reg[31:0] + d_reg};
                end
            end
            if (cmd.finish) begin
                mac_reg <= chain_reg;
                cnt_reg <= '0;
            end
        end
    end

    assign sts.comp_busy = busy_reg || full_reg || cmd.comp_start;
    assign sts.blk_full  = cmd.put_byte && (pos == 6'd63);
    assign sts.pos       = pos;
    assign sts.byte_idx  = bidx_reg;
    assign sts.len_idx   = lidx_reg;
    assign mac           = mac_reg;

endmodule

### rtl/core/hmac_md5_stream.sv
// ----------------------------------------------------------------------------
// hmac_md5_stream
// HMAC-MD5 over a word stream with a 16-byte key held in APB registers.
// ----------------------------------------------------------------------------
// One MD5 round runs per cycle in a single shared round unit, and one message
// byte is written per cycle into the block buffer, pausing while each filled
// 64-byte block compresses. A new word waits until the previous one is written.
// The first word of a message also compresses the inner key block; the last
// word adds padding (up to 72 bytes and one or two compressions) plus two more
// compressions for the outer hash before the MAC word is offered.
module hmac_md5_stream import hmd5_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data
);

    logic [63:0]  key_low_reg, key_high_reg;
    logic [4:0]   key_len_reg;
    logic [127:0] key_masked, mac;
    logic [4:0]   klen;
    cmd_t         cmd;
    sts_t         sts;

    assign pready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= '0;
        end else if (psel && penable && pwrite) begin
            case ({3'b000, paddr})
                ADDR_KEY_LOW:  key_low_reg  <= pwdata;
                ADDR_KEY_HIGH: key_high_reg <= pwdata;
                ADDR_KEY_LEN:  key_len_reg  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case ({3'b000, paddr})
            ADDR_KEY_LOW:  prdata = key_low_reg;
            ADDR_KEY_HIGH: prdata = key_high_reg;
            ADDR_KEY_LEN:  prdata = {59'd0, key_len_reg};
            default:       prdata = '0;
        endcase
    end

    // Zero key bytes at and beyond the key length
    assign klen = (key_len_reg > 5'd16) ? 5'd16 : key_len_reg;
    always_comb begin
        key_masked = {key_high_reg, key_low_reg};
        for (int i = 0; i < 16; i++)
            if (i >= klen) key_masked[8*i +: 8] = 8'h00;
    end

    hmd5_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_word   (s_data),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    hmd5_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .msg_word (s_data.msg_word),
        .key_in   (key_masked),
        .sts      (sts),
        .mac      (mac)
    );

    assign m_data.mac_low  = mac[63:0];
    assign m_data.mac_high = mac[127:64];

    // Checks
    a_no_accept_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken with result pending");
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data)) else $error("mac changed");
    a_len_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        klen <= 5'd16) else $error("key length clamp");

endmodule

### test/hmac_md5_stream_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmac_md5_stream_test
// Streams random and directed messages through the HMAC-MD5 block under
// several keys, predicts each MAC in a behavioral model and compares it.
// ----------------------------------------------------------------------------
class mac_scoreboard;
    logic [31:0] key_words [4];
    logic [63:0] key_lo, key_hi;
    logic [4:0]  key_len;
    logic [31:0] chain [4];
    logic [31:0] blk [16];
    logic [63:0] nbytes;
    bit          open;
    logic [127:0] pending_macs [$];
    int          errors;

    function new();
        key_lo = '0; key_hi = '0; key_len = '0;
        chain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
        nbytes = '0; open = 0; errors = 0;
        foreach (blk[i]) blk[i] = '0;
    endfunction

    static function logic [31:0] round_k(int i);
        return 32'(longint'($floor($pow(2.0, 32) *
            (($sin(real'(i + 1)) < 0) ? -$sin(real'(i + 1)) : $sin(real'(i + 1))))));
    endfunction

    // One MD5 compression of m into st
    static function void md5_block(ref logic [31:0] st [4], input logic [31:0] m [16]);
        int sh [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        logic [31:0] a, b, c, d, f, t, x;
        int g;
        a = st[0]; b = st[1]; c = st[2]; d = st[3];
        for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
                f = (b & c) | (~b & d); g = i;
            end else if (i < 32) begin
                f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
            end else if (i < 48) begin
                f = b ^ c ^ d; g = (3 * i + 5) % 16;
            end else begin
                f = c ^ (b | ~d); g = (7 * i) % 16;
            end
            x = a + f + round_k(i) + m[g];
            t = d; d = c; c = b;
            b = b + ((x << sh[(i / 16) * 4 + i % 4]) | (x >> (32 - sh[(i / 16) * 4 + i % 4])));
            a = t;
        end
        st[0] += a; st[1] += b; st[2] += c; st[3] += d;
    endfunction

    function void pad_key(ref logic [31:0] st [4], input logic [31:0] pad);
        logic [31:0] m [16];
        for (int i = 0; i < 16; i++) m[i] = ((i < 4) ? key_words[i] : 32'h0) ^ pad;
        st = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
        md5_block(st, m);
    endfunction

    function void add_byte(logic [7:0] v);
        int p;
        p = int'(nbytes[5:0]);
        blk[p / 4][(p % 4) * 8 +: 8] = v;
        nbytes++;
        if (p == 63) md5_block(chain, blk);
    endfunction

    function void set_reg(int idx, logic [63:0] v);
        if (idx == 0) key_lo = v;
        else if (idx == 1) key_hi = v;
        else key_len = v[4:0];
    endfunction

    // Note one accepted input word; queue a MAC on the last word
    function void note_word(hmd5_pkg::in_word_t w);
        int n, len;
        logic [63:0] lo, hi, bits;
        logic [31:0] outer [4], m [16];
        if (!open) begin
            len = (key_len > 16) ? 16 : key_len;
            lo = key_lo; hi = key_hi;
            if (len < 8) begin
                lo &= (64'h1 << (len * 8)) - 1; hi = 0;
            end else if (len < 16) begin
                hi &= (64'h1 << ((len - 8) * 8)) - 1;
            end
            key_words = '{lo[31:0], lo[63:32], hi[31:0], hi[63:32]};
            pad_key(chain, 32'h36363636);
            nbytes = 64; open = 1;
            foreach (blk[i]) blk[i] = '0;
        end
        n = (w.valid_bytes > 4) ? 4 : w.valid_bytes;
        for (int i = 0; i < n; i++) add_byte(w.msg_word[i * 8 +: 8]);
        if (!w.last) return;
        bits = nbytes << 3;
        add_byte(8'h80);
        while (nbytes[5:0] != 56) add_byte(8'h00);
        for (int i = 0; i < 8; i++) add_byte(bits[i * 8 +: 8]);
        pad_key(outer, 32'h5c5c5c5c);
        foreach (m[i]) m[i] = '0;
        for (int i = 0; i < 4; i++) m[i] = chain[i];
        m[4] = 32'h80; m[14] = 32'd640;
        md5_block(outer, m);
        pending_macs.push_back({outer[3], outer[2], outer[1], outer[0]});
        chain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
        nbytes = 0; open = 0;
    endfunction

    function void check_mac(hmd5_pkg::out_word_t r);
        logic [127:0] e;
        if (pending_macs.size() == 0) begin
            $display("%0t: unexpected MAC %h", $time, r);
            errors++;
            return;
        end
        e = pending_macs.pop_front();
        if (r.mac_low !== e[63:0]) begin
            $display("%0t: mac_low expected %h actual %h", $time, e[63:0], r.mac_low);
            errors++;
        end
        if (r.mac_high !== e[127:64]) begin
            $display("%0t: mac_high expected %h actual %h", $time, e[127:64], r.mac_high);
            errors++;
        end
    endfunction
endclass

module hmac_md5_stream_test;
    import hmd5_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_valid = 0;
    logic        s_ready;
    in_word_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    out_word_t   m_data;

    mac_scoreboard mac_board = new();
    int sent_words;

    hmac_md5_stream dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // Receiver: stalls on its own pattern, quiet stretches included
    int stall_mode;
    always @(posedge aclk) begin
        if (m_valid && m_ready) mac_board.check_mac(m_data);
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    end
    always @(negedge aclk) begin
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    task automatic write_reg(int idx, logic [63:0] v);
        @(negedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= 5'(idx * 8); pwdata <= v;
        @(negedge aclk);
        penable <= 1;
        @(posedge aclk);
        mac_board.set_reg(idx, v);
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_word(logic [31:0] w, logic [2:0] nb, logic lst);
        in_word_t d;
        d.msg_word = w; d.valid_bytes = nb; d.last = lst;
        s_data <= d;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
        mac_board.note_word(d);
        sent_words++;
        @(negedge aclk);
    endtask

    // Called at a falling edge right after the last accepted word
    task automatic drain();
        s_valid <= 0;
        @(negedge aclk);
        while (mac_board.pending_macs.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    // Random message: mostly full words, occasional odd sizes, bursts and gaps
    task automatic send_message(int nwords);
        int burst;
        burst = $urandom_range(1, 8);
        for (int i = 0; i < nwords; i++) begin
            send_word($urandom, ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4,
                      i == nwords - 1);
            if (--burst == 0) begin
                s_valid <= 0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
                burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed: empty message with zero key, then edge keys and fields
        send_word(32'h0, 3'd0, 1'b1);
        send_word(32'hffffffff, 3'd7, 1'b1);
        drain();
        write_reg(0, 64'hffffffffffffffff);
        write_reg(1, 64'hffffffffffffffff);
        write_reg(2, 64'd16);
        send_word(32'h0, 3'd4, 1'b0);
        send_word(32'hffffffff, 3'd4, 1'b0);
        send_word(32'h12345678, 3'd5, 1'b0);
        send_word(32'h0, 3'd6, 1'b0);
        send_word(32'h89abcdef, 3'd1, 1'b1);
        drain();
        write_reg(2, 64'd31);
        send_word(32'hdeadbeef, 3'd3, 1'b1);
        // Key change mid-message applies from the next one
        send_word(32'hcafef00d, 3'd2, 1'b0);
        drain();
        write_reg(2, 64'd7);
        send_word(32'h5a5a5a5a, 3'd4, 1'b1);
        send_word(32'h0, 3'd0, 1'b1);
        drain();

        // Random phases with varying keys
        while (sent_words < 620) begin
            write_reg(0, {$urandom, $urandom});
            write_reg(1, {$urandom, $urandom});
            write_reg(2, 64'($urandom_range(0, 31)));
            for (int k = 0; k < 6; k++)
                send_message(($urandom_range(0, 5) == 0) ? $urandom_range(14, 40)
                                                         : $urandom_range(1, 12));
            drain();
        end

        if (mac_board.errors == 0 && mac_board.pending_macs.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule
